@@ rtl/core/eleiu_pkg.sv @@
package eleiu_pkg;

   // Field widths of one cell beat and one result beat.
   localparam int VALUE_W    = 32;
   localparam int RESULT_W   = 64;
   localparam int GAMMA_W    = 19;
   localparam int DIMS_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Default number of fraction bits of the Q formats.
   localparam int ELEIU_FRAC_BITS = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_RATIO       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_VOLUME       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESULT_WEIGHT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_DIMENSIONS = 2'd3;

   // Register values after reset.
   localparam logic [GAMMA_W-1:0]    GAMMA_RESET  = 19'd91750;
   localparam logic [VALUE_W-1:0]    VOLUME_RESET = 32'd65536;
   localparam logic [VALUE_W-1:0]    WEIGHT_RESET = 32'd65536;
   localparam logic [DIMS_W-1:0]     DIMS_RESET   = 2'd3;

   // ln(2) in unsigned Q0.32, rounded.
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   // Iteration counts of the shared divider and logarithm.
   localparam int DIV_STEPS = 96;
   localparam int LOG_STEPS = 32;

   localparam logic [RESULT_W-1:0] S64_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
   localparam logic [RESULT_W-1:0] S64_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

endpackage

@@ rtl/core/eleiu_req_if.sv @@
interface eleiu_req_if
   import eleiu_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  cell_density;
   logic signed [VALUE_W-1:0]  cell_energy;
   logic signed [VALUE_W-1:0]  momentum_x;
   logic signed [VALUE_W-1:0]  momentum_y;
   logic signed [VALUE_W-1:0]  momentum_z;
   logic                       final_cell;

   modport source (output valid, cell_density, cell_energy, momentum_x, momentum_y,
                   momentum_z, final_cell, input ready);
   modport sink   (input valid, cell_density, cell_energy, momentum_x, momentum_y,
                   momentum_z, final_cell, output ready);
endinterface

@@ rtl/core/eleiu_rsp_if.sv @@
interface eleiu_rsp_if
   import eleiu_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic signed [RESULT_W-1:0]  weighted_integral;
   logic                        invalid_seen;

   modport source (output valid, weighted_integral, invalid_seen, input ready);
   modport sink   (input valid, weighted_integral, invalid_seen, output ready);
endinterface

@@ rtl/core/euler_log_entropy_integral_unit.sv @@
// A valid cell runs two divider passes, three logarithms (each normalized, then squared
// bit by bit) and one momentum square per active dimension, with shared multiplies between.
// Non-positive density skips a cell on entry, non-positive pressure after the first division.
// A final cell then forms the weight product, and waits out any result stall, before its beat.
// One cell at a time; the shared 32x32 multiplier and the 1-bit divider set this.
// Reset (synchronous, active high) clears sum, flag and result valid; registers reload defaults.
module euler_log_entropy_integral_unit
   import eleiu_pkg::*;
#(
   parameter int FRAC_BITS = ELEIU_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   eleiu_req_if.sink              req_bus,
   eleiu_rsp_if.source            rsp_bus,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_DIV, ST_KIN, ST_LOG_NORM, ST_LOG_ITER, ST_LOG_DONE,
      ST_MUL_LO, ST_MUL_HI, ST_MUL_DONE, ST_HDONE, ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_GL, OP_S, OP_RS, OP_TERM, OP_RES
   } op_type;

   localparam logic [6:0] DIV_LAST = 7'(DIV_STEPS - 1);
   localparam logic [6:0] LOG_LAST = 7'(LOG_STEPS - 1);
   localparam logic [31:0] ONE_Q   = 32'(1) << FRAC_BITS;

   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   state_type          state_ff, state_in;
   state_type          div_ret_ff, div_ret_in;
   op_type             op_ff, op_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic [31:0]        rho_ff, rho_in;
   logic [31:0]        en_ff, en_in;
   logic [31:0]        mom_ff [3];
   logic [31:0]        mom_in [3];
   logic               final_ff, final_in;
   logic [95:0]        prod_ff, prod_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        dvsr_ff, dvsr_in;
   logic [31:0]        m_ff, m_in;
   logic [4:0]         msb_ff, msb_in;
   logic [31:0]        frac_ff, frac_in;
   logic [1:0]         log_sel_ff, log_sel_in;
   logic [63:0]        lp_ff, lp_in;
   logic [31:0]        dd_ff, dd_in;
   logic [63:0]        opa_ff, opa_in;
   logic [31:0]        opb_ff, opb_in;
   logic               neg_ff, neg_in;
   logic               sh32_ff, sh32_in;
   logic               hneg_ff, hneg_in;
   logic [63:0]        sum_ff, sum_in;
   logic               sticky_ff, sticky_in;
   logic [GAMMA_W-1:0] gamma_ff, gamma_in;
   logic [31:0]        vol_ff, vol_in;
   logic [31:0]        weight_ff, weight_in;
   logic [1:0]         dims_ff, dims_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_integral_ff, rsp_integral_in;
   logic               rsp_invalid_ff, rsp_invalid_in;

   // Shared multiplier operands and product.
   logic [31:0] mul_a, mul_b, mom_mag;
   logic [63:0] mul_p;
   logic [1:0]  dim_last;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    mom_mag = mag32(mom_ff[0]);
         2'd1:    mom_mag = mag32(mom_ff[1]);
         default: mom_mag = mag32(mom_ff[2]);
      endcase
      case (state_ff)
         ST_SQ: begin
            mul_a = mom_mag;
            mul_b = mom_mag;
         end
         ST_LOG_ITER: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         ST_MUL_HI: begin
            mul_a = opa_ff[63:32];
            mul_b = opb_ff;
         end
         default: begin
            mul_a = opa_ff[31:0];
            mul_b = opb_ff;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign dim_last = (dims_ff == 2'd0) ? 2'd0 : dims_ff - 2'd1;

   // Gamma clamped above one, and gamma minus one.
   logic [31:0] g_val, g1_val;
   assign g_val  = ({13'd0, gamma_ff} <= ONE_Q) ? ONE_Q + 32'd1 : {13'd0, gamma_ff};
   assign g1_val = g_val - ONE_Q;

   // Product scaled down, truncated on the magnitude and saturated.
   logic [95:0] shr;
   logic [63:0] cap, rmag, smul_res;
   always_comb begin
      shr      = sh32_ff ? (prod_ff >> 32) : (prod_ff >> FRAC_BITS);
      cap      = neg_ff ? S64_MIN : S64_MAX;
      rmag     = (|shr[95:64] || shr[63:0] > cap) ? cap : shr[63:0];
      smul_res = neg_ff ? (64'd0 - rmag) : rmag;
   end

   // Divider step: one quotient bit per cycle.
   logic [32:0] rem_sh;
   logic        div_ge;
   assign rem_sh = {rem_ff, prod_ff[95]};
   assign div_ge = rem_sh >= {1'b0, dvsr_ff};

   // Logarithm step: square the mantissa and renormalize.
   logic [32:0] sq_top;
   assign sq_top = mul_p[63:31];

   // Reduced energy, log result, running sum with saturation.
   logic [63:0] d_val, log_val, t_val, sum_add;
   logic        sum_ovf;
   assign d_val   = {{32{en_ff[31]}}, en_ff} - prod_ff[63:0];
   assign log_val = {32'(msb_ff) - 32'(FRAC_BITS), frac_ff};
   assign t_val   = lp_ff - smul_res;
   assign sum_add = sum_ff + smul_res;
   assign sum_ovf = (sum_ff[63] == smul_res[63]) && (sum_add[63] != sum_ff[63]);

   logic req_fire, rsp_fire;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = rsp_valid_ff && rsp_bus.ready;

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.weighted_integral = rsp_integral_ff;
   assign rsp_bus.invalid_seen      = rsp_invalid_ff;

   // Sequencer next-state and datapath.
   always_comb begin
      state_in        = state_ff;
      div_ret_in      = div_ret_ff;
      op_in           = op_ff;
      cnt_in          = cnt_ff;
      rho_in          = rho_ff;
      en_in           = en_ff;
      mom_in          = mom_ff;
      final_in        = final_ff;
      prod_in         = prod_ff;
      rem_in          = rem_ff;
      dvsr_in         = dvsr_ff;
      m_in            = m_ff;
      msb_in          = msb_ff;
      frac_in         = frac_ff;
      log_sel_in      = log_sel_ff;
      lp_in           = lp_ff;
      dd_in           = dd_ff;
      opa_in          = opa_ff;
      opb_in          = opb_ff;
      neg_in          = neg_ff;
      sh32_in         = sh32_ff;
      hneg_in         = hneg_ff;
      sum_in          = sum_ff;
      sticky_in       = sticky_ff;
      gamma_in        = gamma_ff;
      vol_in          = vol_ff;
      weight_in       = weight_ff;
      dims_in         = dims_ff;
      rsp_valid_in    = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_integral_in = rsp_integral_ff;
      rsp_invalid_in  = rsp_invalid_ff;

      // Configuration writes.
      if (csr_write_en) begin
         case (csr_index)
            CSR_GAMMA_RATIO:       gamma_in  = csr_write_data[GAMMA_W-1:0];
            CSR_CELL_VOLUME:       vol_in    = csr_write_data;
            CSR_RESULT_WEIGHT:     weight_in = csr_write_data;
            CSR_ACTIVE_DIMENSIONS: dims_in   = csr_write_data[DIMS_W-1:0];
            default:               dims_in   = dims_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rho_in    = req_bus.cell_density;
               en_in     = req_bus.cell_energy;
               mom_in[0] = req_bus.momentum_x;
               mom_in[1] = req_bus.momentum_y;
               mom_in[2] = req_bus.momentum_z;
               final_in  = req_bus.final_cell;
               prod_in   = '0;
               cnt_in    = '0;
               if (req_bus.cell_density[31] || req_bus.cell_density == '0) begin
                  sticky_in = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  state_in  = ST_SQ;
               end
            end
         end
         // Squared momentum, one component a cycle.
         ST_SQ: begin
            prod_in = prod_ff + {32'd0, mul_p};
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff[1:0] == dim_last) begin
               dvsr_in    = {rho_ff[30:0], 1'b0};
               rem_in     = '0;
               cnt_in     = '0;
               div_ret_in = ST_KIN;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? 32'(rem_sh - {1'b0, dvsr_ff}) : rem_sh[31:0];
            prod_in = {prod_ff[94:0], div_ge};
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = div_ret_ff;
            end
         end
         // Reduced energy; a non-positive value skips the cell.
         ST_KIN: begin
            if (d_val[63] || d_val == '0) begin
               sticky_in = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               dd_in      = d_val[31:0];
               m_in       = g1_val;
               msb_in     = 5'd31;
               log_sel_in = 2'd0;
               state_in   = ST_LOG_NORM;
            end
         end
         ST_LOG_NORM: begin
            if (m_ff[31]) begin
               cnt_in   = '0;
               state_in = ST_LOG_ITER;
            end else begin
               m_in   = {m_ff[30:0], 1'b0};
               msb_in = msb_ff - 5'd1;
            end
         end
         ST_LOG_ITER: begin
            m_in    = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
            frac_in = {frac_ff[30:0], sq_top[32]};
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == LOG_LAST) begin
               state_in = ST_LOG_DONE;
            end
         end
         // Chain of logarithms: gamma-1, reduced energy, density.
         ST_LOG_DONE: begin
            case (log_sel_ff)
               2'd0: begin
                  lp_in      = log_val;
                  m_in       = dd_ff;
                  msb_in     = 5'd31;
                  log_sel_in = 2'd1;
                  state_in   = ST_LOG_NORM;
               end
               2'd1: begin
                  lp_in      = lp_ff + log_val;
                  m_in       = rho_ff;
                  msb_in     = 5'd31;
                  log_sel_in = 2'd2;
                  state_in   = ST_LOG_NORM;
               end
               default: begin
                  opa_in   = mag64(log_val);
                  opb_in   = g_val;
                  neg_in   = log_val[63];
                  sh32_in  = 1'b0;
                  op_in    = OP_GL;
                  state_in = ST_MUL_LO;
               end
            endcase
         end
         ST_MUL_LO: begin
            prod_in  = {32'd0, mul_p};
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_in  = prod_ff + {mul_p, 32'd0};
            state_in = ST_MUL_DONE;
         end
         ST_MUL_DONE: begin
            case (op_ff)
               OP_GL: begin
                  opa_in   = mag64(t_val);
                  opb_in   = LN2_Q32;
                  neg_in   = t_val[63];
                  hneg_in  = ~t_val[63];
                  sh32_in  = 1'b1;
                  op_in    = OP_S;
                  state_in = ST_MUL_LO;
               end
               OP_S: begin
                  opa_in   = mag64(smul_res);
                  opb_in   = rho_ff;
                  op_in    = OP_RS;
                  state_in = ST_MUL_LO;
               end
               OP_RS: begin
                  dvsr_in    = g1_val;
                  rem_in     = '0;
                  cnt_in     = '0;
                  div_ret_in = ST_HDONE;
                  state_in   = ST_DIV;
               end
               OP_TERM: begin
                  if (sum_ovf) begin
                     sum_in = smul_res[63] ? S64_MIN : S64_MAX;
                  end else begin
                     sum_in = sum_add;
                  end
                  state_in = ST_FINISH;
               end
               default: begin
                  if (!rsp_valid_ff || rsp_bus.ready) begin
                     rsp_valid_in    = 1'b1;
                     rsp_integral_in = smul_res;
                     rsp_invalid_in  = sticky_ff;
                     sum_in          = '0;
                     sticky_in       = 1'b0;
                     state_in        = ST_IDLE;
                  end
               end
            endcase
         end
         // Entropy density magnitude, then its product with the cell volume.
         ST_HDONE: begin
            opa_in   = (|prod_ff[95:63]) ? S64_MAX : {1'b0, prod_ff[62:0]};
            opb_in   = vol_ff;
            neg_in   = hneg_ff;
            sh32_in  = 1'b0;
            op_in    = OP_TERM;
            state_in = ST_MUL_LO;
         end
         ST_FINISH: begin
            if (final_ff) begin
               opa_in   = mag64(sum_ff);
               opb_in   = mag32(weight_ff);
               neg_in   = sum_ff[63] ^ weight_ff[31];
               sh32_in  = 1'b0;
               op_in    = OP_RES;
               state_in = ST_MUL_LO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gamma_ff     <= GAMMA_RESET;
         vol_ff       <= VOLUME_RESET;
         weight_ff    <= WEIGHT_RESET;
         dims_ff      <= DIMS_RESET;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
         gamma_ff     <= gamma_in;
         vol_ff       <= vol_in;
         weight_ff    <= weight_in;
         dims_ff      <= dims_in;
      end
      div_ret_ff      <= div_ret_in;
      op_ff           <= op_in;
      cnt_ff          <= cnt_in;
      rho_ff          <= rho_in;
      en_ff           <= en_in;
      mom_ff          <= mom_in;
      final_ff        <= final_in;
      prod_ff         <= prod_in;
      rem_ff          <= rem_in;
      dvsr_ff         <= dvsr_in;
      m_ff            <= m_in;
      msb_ff          <= msb_in;
      frac_ff         <= frac_in;
      log_sel_ff      <= log_sel_in;
      lp_ff           <= lp_in;
      dd_ff           <= dd_in;
      opa_ff          <= opa_in;
      opb_ff          <= opb_in;
      neg_ff          <= neg_in;
      sh32_ff         <= sh32_in;
      hneg_ff         <= hneg_in;
      rsp_integral_ff <= rsp_integral_in;
      rsp_invalid_ff  <= rsp_invalid_in;
   end

   // The partial remainder always stays below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < dvsr_ff))
      else $error("divider remainder not below divisor");

   // The log mantissa stays normalized while squaring.
   a_log_norm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOG_ITER) |-> m_ff[31])
      else $error("log mantissa lost normalization");

   // The momentum step never runs past the active dimensions.
   a_sq_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ) |-> (cnt_ff[1:0] <= dim_last))
      else $error("momentum index out of range");

   // A new result beat leaves the sum and flag cleared for the next volume.
   a_res_clear: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (sum_ff == '0 && !sticky_ff))
      else $error("sum not cleared with result");

   // An accepted beat always starts work.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("accepted beat did not start work");

endmodule
